### rtl/vmdle_pkg.sv
// Package for the voice modem DLE stream parser: mode, kind and operation codes,
// control characters, register indexes, match words and controller/datapath structs.
// No dependencies.
`default_nettype none

package vmdle_pkg;

   // Modes
   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_READY    = 3'd1;
   localparam logic [2:0] MODE_INITREC  = 3'd2;
   localparam logic [2:0] MODE_DONE     = 3'd3;
   localparam logic [2:0] MODE_INITPLAY = 3'd4;
   localparam logic [2:0] MODE_REC      = 3'd5;

   // Input operations
   localparam logic [1:0] OP_BYTE     = 2'd0;
   localparam logic [1:0] OP_SET_MODE = 2'd1;
   localparam logic [1:0] OP_RESUME   = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_AUDIO = 2'd0;
   localparam logic [1:0] KIND_CODE  = 2'd1;
   localparam logic [1:0] KIND_LINE  = 2'd2;
   localparam logic [1:0] KIND_PLAY  = 2'd3;

   // Control characters and code ranges
   localparam logic [7:0] CH_ETX         = 8'd3;
   localparam logic [7:0] CH_LF          = 8'd10;
   localparam logic [7:0] CH_CR          = 8'd13;
   localparam logic [7:0] CH_DLE         = 8'd16;
   localparam logic [7:0] CODE_LOW_BASE  = 8'd32;
   localparam logic [7:0] CODE_HIGH_BASE = 8'd96;
   localparam logic [7:0] CODE_END       = 8'd160;

   // Register indexes
   localparam logic [1:0] REG_ACCEPT_ALL = 2'd0;
   localparam logic [1:0] REG_MASK_LOW   = 2'd1;
   localparam logic [1:0] REG_MASK_HIGH  = 2'd2;
   localparam logic [1:0] REG_DLE_CONV   = 2'd3;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam int CONNECT_LEN = 7;
   localparam int VCON_LEN    = 4;

   function automatic logic [7:0] connect_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h43; // C
         3'd1:    c = 8'h4F; // O
         3'd2:    c = 8'h4E; // N
         3'd3:    c = 8'h4E; // N
         3'd4:    c = 8'h45; // E
         3'd5:    c = 8'h43; // C
         3'd6:    c = 8'h54; // T
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] vcon_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h56; // V
         3'd1:    c = 8'h43; // C
         3'd2:    c = 8'h4F; // O
         3'd3:    c = 8'h4E; // N
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   typedef struct packed {
      logic        accept_all;
      logic [63:0] mask_low;
      logic [63:0] mask_high;
      logic        dle_conv;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic load_imm0;
      logic load_imm1;
      logic load_play;
      logic load_char;
      logic next_char;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] dec_count;
      logic       dec_run;
      logic       dec_play;
      logic       out_free;
      logic       imm_two;
      logic       run_last;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/vmdle_ifs.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
// No dependencies.
`default_nettype none

interface vmdle_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic [2:0] new_mode;

   modport source(output valid, operation, data_byte, new_mode, input ready);
   modport sink(input valid, operation, data_byte, new_mode, output ready);
endinterface

interface vmdle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       last;
   logic [2:0] mode_now;

   modport source(output valid, kind, value, last, mode_now, input ready);
   modport sink(input valid, kind, value, last, mode_now, output ready);
endinterface

`default_nettype wire

### rtl/vmdle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vmdle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/vmdle_csr.sv
// APB-style configuration registers of the DLE stream parser.
// Depends on vmdle_pkg.
`default_nettype none

module vmdle_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [vmdle_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [vmdle_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [vmdle_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                      pready,
   output vmdle_pkg::cfg_type                        cfg
);

   vmdle_pkg::cfg_type cfg_ff;
   logic [1:0]         reg_idx;
   logic               wr_stb;

   // registers sit on 8-byte boundaries
   assign reg_idx = paddr[4:3];
   assign wr_stb  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accept_all <= 1'b1;
         cfg_ff.mask_low   <= '0;
         cfg_ff.mask_high  <= '0;
         cfg_ff.dle_conv   <= 1'b0;
      end else if (wr_stb) begin
         case (reg_idx)
            vmdle_pkg::REG_ACCEPT_ALL: cfg_ff.accept_all <= pwdata[0];
            vmdle_pkg::REG_MASK_LOW:   cfg_ff.mask_low   <= pwdata;
            vmdle_pkg::REG_MASK_HIGH:  cfg_ff.mask_high  <= pwdata;
            vmdle_pkg::REG_DLE_CONV:   cfg_ff.dle_conv   <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         vmdle_pkg::REG_ACCEPT_ALL: prdata = {63'd0, cfg_ff.accept_all};
         vmdle_pkg::REG_MASK_LOW:   prdata = cfg_ff.mask_low;
         vmdle_pkg::REG_MASK_HIGH:  prdata = cfg_ff.mask_high;
         vmdle_pkg::REG_DLE_CONV:   prdata = {63'd0, cfg_ff.dle_conv};
         default:                   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/vmdle_datapath.sv
// Datapath of the DLE stream parser: item register, mode/DLE/line state, byte
// decode, line store RAM, running word matches and the result output register.
// Depends on vmdle_pkg and vmdle_ram.
`default_nettype none

module vmdle_datapath #(
   parameter int LINE_DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire vmdle_pkg::cfg_type       cfg,
   input  wire vmdle_pkg::ctrl_cmd_type  cmd,
   output vmdle_pkg::dp_status_type      status,
   input  wire logic [1:0]               req_operation,
   input  wire logic [7:0]               req_data_byte,
   input  wire logic [2:0]               req_new_mode,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic      [1:0]               rsp_kind,
   output logic      [7:0]               rsp_value,
   output logic                          rsp_last,
   output logic      [2:0]               rsp_mode_now
);

   localparam int LW = $clog2(LINE_DEPTH);

   // item register
   logic [1:0]    op_ff;
   logic [7:0]    byte_ff;
   logic [2:0]    nm_ff;

   // parser state
   logic [2:0]    mode_ff,  mode_in;
   logic          pend_ff,  pend_in;
   logic [LW-1:0] len_ff,   len_in;
   logic          conn_ok_ff, conn_ok_in;
   logic          vcon_ok_ff, vcon_ok_in;

   // latched results of the committed item
   logic          imm_two_ff;
   logic [1:0]    imm0_kind_ff;
   logic [7:0]    imm0_val_ff;
   logic [LW-1:0] run_len_ff;
   logic [LW-1:0] idx_ff;

   // output register
   logic          rsp_valid_ff;
   logic [1:0]    rsp_kind_ff;
   logic [7:0]    rsp_value_ff;
   logic          rsp_last_ff;
   logic [2:0]    rsp_mode_ff;

   // decode
   logic          cmd_mode;
   logic          code_ok;
   logic          store;
   logic          wr_en;
   logic [1:0]    cnt;
   logic [1:0]    kind0;
   logic [7:0]    val0;
   logic          run;
   logic          play;
   logic [7:0]    byte_m_low;
   logic [7:0]    byte_m_high;

   logic          rd_en;
   logic [LW-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign cmd_mode = (mode_ff == vmdle_pkg::MODE_READY) ||
                     (mode_ff == vmdle_pkg::MODE_INITREC) ||
                     (mode_ff == vmdle_pkg::MODE_DONE) ||
                     (mode_ff == vmdle_pkg::MODE_INITPLAY);

   assign byte_m_low  = byte_ff - vmdle_pkg::CODE_LOW_BASE;
   assign byte_m_high = byte_ff - vmdle_pkg::CODE_HIGH_BASE;

   always_comb begin
      if (cfg.accept_all) begin
         code_ok = (byte_ff >= vmdle_pkg::CODE_LOW_BASE);
      end else if (byte_ff >= vmdle_pkg::CODE_LOW_BASE &&
                   byte_ff < vmdle_pkg::CODE_HIGH_BASE) begin
         code_ok = cfg.mask_low[byte_m_low[5:0]];
      end else if (byte_ff >= vmdle_pkg::CODE_HIGH_BASE &&
                   byte_ff < vmdle_pkg::CODE_END) begin
         code_ok = cfg.mask_high[byte_m_high[5:0]];
      end else begin
         code_ok = 1'b0;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      len_in     = len_ff;
      conn_ok_in = conn_ok_ff;
      vcon_ok_in = vcon_ok_ff;
      store      = 1'b0;
      wr_en      = 1'b0;
      cnt        = 2'd0;
      kind0      = vmdle_pkg::KIND_AUDIO;
      val0       = byte_ff;
      run        = 1'b0;
      play       = 1'b0;
      case (op_ff)
         vmdle_pkg::OP_SET_MODE: begin
            if (nm_ff <= vmdle_pkg::MODE_REC) begin
               mode_in = nm_ff;
            end
         end
         vmdle_pkg::OP_RESUME: begin
            pend_in = 1'b0;
            len_in  = '0;
         end
         vmdle_pkg::OP_BYTE: begin
            if (cmd_mode) begin
               if (byte_ff == vmdle_pkg::CH_CR) begin
                  // dropped, pending DLE kept
               end else if (byte_ff == vmdle_pkg::CH_LF) begin
                  if (len_ff != '0) begin
                     run    = 1'b1;
                     len_in = '0;
                     if (mode_ff == vmdle_pkg::MODE_INITREC &&
                         len_ff == LW'(vmdle_pkg::CONNECT_LEN) && conn_ok_ff) begin
                        mode_in = vmdle_pkg::MODE_REC;
                        pend_in = 1'b0;
                     end else if (mode_ff == vmdle_pkg::MODE_DONE &&
                                  len_ff == LW'(vmdle_pkg::VCON_LEN) && vcon_ok_ff) begin
                        mode_in = vmdle_pkg::MODE_READY;
                     end else if (mode_ff == vmdle_pkg::MODE_INITPLAY) begin
                        play    = 1'b1;
                        mode_in = vmdle_pkg::MODE_READY;
                     end
                  end
               end else if (byte_ff == vmdle_pkg::CH_DLE && !pend_ff) begin
                  pend_in = 1'b1;
               end else if (pend_ff && byte_ff != vmdle_pkg::CH_DLE) begin
                  pend_in = 1'b0;
                  if (code_ok) begin
                     cnt   = 2'd1;
                     kind0 = vmdle_pkg::KIND_CODE;
                  end
               end else begin
                  // plain character, or DLE DLE storing one DLE
                  pend_in = 1'b0;
                  store   = 1'b1;
               end
            end else if (mode_ff == vmdle_pkg::MODE_REC) begin
               if (!pend_ff) begin
                  if (byte_ff == vmdle_pkg::CH_DLE) begin
                     pend_in = 1'b1;
                  end else begin
                     cnt = 2'd1;
                  end
               end else begin
                  pend_in = 1'b0;
                  if (byte_ff == vmdle_pkg::CH_ETX) begin
                     mode_in = vmdle_pkg::MODE_DONE;
                     len_in  = '0;
                  end else if (byte_ff >= vmdle_pkg::CODE_LOW_BASE) begin
                     if (code_ok) begin
                        cnt   = 2'd1;
                        kind0 = vmdle_pkg::KIND_CODE;
                     end
                  end else begin
                     cnt  = cfg.dle_conv ? 2'd1 : 2'd2;
                     val0 = vmdle_pkg::CH_DLE;
                  end
               end
            end
         end
         default: ;
      endcase

      // append to line; running prefix match against both words
      if (store && len_ff < LW'(LINE_DEPTH - 1)) begin
         wr_en      = 1'b1;
         len_in     = len_ff + LW'(1);
         conn_ok_in = (len_ff == '0 || conn_ok_ff) &&
                      (len_ff < LW'(vmdle_pkg::CONNECT_LEN)) &&
                      (byte_ff == vmdle_pkg::connect_char(len_ff[2:0]));
         vcon_ok_in = (len_ff == '0 || vcon_ok_ff) &&
                      (len_ff < LW'(vmdle_pkg::VCON_LEN)) &&
                      (byte_ff == vmdle_pkg::vcon_char(len_ff[2:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         byte_ff <= req_data_byte;
         nm_ff   <= req_new_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= vmdle_pkg::MODE_IDLE;
         pend_ff <= 1'b0;
         len_ff  <= '0;
      end else if (cmd.commit) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         len_ff  <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         conn_ok_ff   <= conn_ok_in;
         vcon_ok_ff   <= vcon_ok_in;
         imm_two_ff   <= (cnt == 2'd2);
         imm0_kind_ff <= kind0;
         imm0_val_ff  <= val0;
         run_len_ff   <= len_ff;
         idx_ff       <= '0;
      end else if (cmd.next_char) begin
         idx_ff <= idx_ff + LW'(1);
      end
   end

   assign rd_en   = (cmd.commit && run) || cmd.next_char;
   assign rd_addr = cmd.next_char ? idx_ff + LW'(1) : '0;

   vmdle_ram #(
      .WIDTH(8),
      .DEPTH(LINE_DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && wr_en),
      .wr_addr (len_ff),
      .wr_data (byte_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // output register; mode is already committed when any result loads
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_imm0 || cmd.load_imm1 || cmd.load_play || cmd.load_char) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_imm0) begin
         rsp_kind_ff  <= imm0_kind_ff;
         rsp_value_ff <= imm0_val_ff;
         rsp_last_ff  <= !imm_two_ff;
         rsp_mode_ff  <= mode_ff;
      end else if (cmd.load_imm1) begin
         rsp_kind_ff  <= vmdle_pkg::KIND_AUDIO;
         rsp_value_ff <= byte_ff;
         rsp_last_ff  <= 1'b1;
         rsp_mode_ff  <= mode_ff;
      end else if (cmd.load_play) begin
         rsp_kind_ff  <= vmdle_pkg::KIND_PLAY;
         rsp_value_ff <= 8'd0;
         rsp_last_ff  <= 1'b0;
         rsp_mode_ff  <= mode_ff;
      end else if (cmd.load_char) begin
         rsp_kind_ff  <= vmdle_pkg::KIND_LINE;
         rsp_value_ff <= rd_data;
         rsp_last_ff  <= status.run_last;
         rsp_mode_ff  <= mode_ff;
      end
   end

   assign status.dec_count = cnt;
   assign status.dec_run   = run;
   assign status.dec_play  = play;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.imm_two   = imm_two_ff;
   assign status.run_last  = (idx_ff == run_len_ff - LW'(1));

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_mode_now = rsp_mode_ff;

endmodule

`default_nettype wire

### rtl/vmdle_ctrl.sv
// Controller of the DLE stream parser: sequences capture, commit and the
// emission of results into the datapath's output register.
// Depends on vmdle_pkg.
`default_nettype none

module vmdle_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire vmdle_pkg::dp_status_type status,
   output vmdle_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EVAL,
      S_IMM0,
      S_IMM1,
      S_PLAY,
      S_CHAR
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.commit = 1'b1;
            if (status.dec_play) begin
               state_in = S_PLAY;
            end else if (status.dec_run) begin
               state_in = S_CHAR;
            end else if (status.dec_count != 2'd0) begin
               state_in = S_IMM0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_IMM0: begin
            if (status.out_free) begin
               cmd.load_imm0 = 1'b1;
               state_in      = status.imm_two ? S_IMM1 : S_IDLE;
            end
         end
         S_IMM1: begin
            if (status.out_free) begin
               cmd.load_imm1 = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_PLAY: begin
            if (status.out_free) begin
               cmd.load_play = 1'b1;
               state_in      = S_CHAR;
            end
         end
         S_CHAR: begin
            // RAM read for the current index was issued at commit or by the last next_char and is held
            if (status.out_free) begin
               cmd.load_char = 1'b1;
               if (status.run_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.next_char = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

### rtl/voice_modem_dle_stream_parser.sv
// Top level of the voice modem DLE stream parser.
// Depends on vmdle_pkg, vmdle_ifs, vmdle_csr, vmdle_ctrl, vmdle_datapath, vmdle_ram.
//
//   port       dir    protocol     carries
//   req_chan   in     valid/ready  operation, data_byte, new_mode
//   rsp_chan   out    valid/ready  kind, value, last, mode_now
//   csr_*      in     APB write    accept_all_codes, code masks, dle_conv
//
// One item at a time: an item is accepted, then committed, then each immediate result
// is loaded in turn, and for a line end the play start (if any) and each line character,
// all fed through the single output register.
// Synchronous reset clears mode, pending DLE, line length and the output valid.
// A stalled rsp_chan holds the sequencer; req_ready stays low until it finishes.
`default_nettype none

module voice_modem_dle_stream_parser #(
   parameter int LINE_DEPTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   vmdle_req_if.sink                                req_chan,
   vmdle_rsp_if.source                              rsp_chan,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [vmdle_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [vmdle_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [vmdle_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                     csr_pready
);

   vmdle_pkg::cfg_type       cfg;
   vmdle_pkg::ctrl_cmd_type  cmd;
   vmdle_pkg::dp_status_type status;
   logic                     ready;

   vmdle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   vmdle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ready),
      .status    (status),
      .cmd       (cmd)
   );

   vmdle_datapath #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .req_operation (req_chan.operation),
      .req_data_byte (req_chan.data_byte),
      .req_new_mode  (req_chan.new_mode),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_kind      (rsp_chan.kind),
      .rsp_value     (rsp_chan.value),
      .rsp_last      (rsp_chan.last),
      .rsp_mode_now  (rsp_chan.mode_now)
   );

   assign req_chan.ready = ready;

endmodule

`default_nettype wire

### rtl/vmdle_checker.sv
// Port-level assertions for the DLE stream parser, bound to the top level.
// Depends on vmdle_pkg and voice_modem_dle_stream_parser.
`default_nettype none

module vmdle_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_value,
   input wire logic       rsp_last,
   input wire logic [2:0] rsp_mode_now
);

   // stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_value) &&
         $stable(rsp_last) && $stable(rsp_mode_now))
      else $error("result changed while stalled");

   // one item in flight: no accept on the cycle after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous item in work");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // play start leads a line run and leaves the modem in ready
   a_play_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == vmdle_pkg::KIND_PLAY |->
         !rsp_last && rsp_mode_now == vmdle_pkg::MODE_READY)
      else $error("bad play start result");

   a_audio_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == vmdle_pkg::KIND_AUDIO |-> rsp_mode_now == vmdle_pkg::MODE_REC)
      else $error("audio byte outside recording");

endmodule

bind voice_modem_dle_stream_parser vmdle_checker u_vmdle_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_kind     (rsp_chan.kind),
   .rsp_value    (rsp_chan.value),
   .rsp_last     (rsp_chan.last),
   .rsp_mode_now (rsp_chan.mode_now)
);

`default_nettype wire
